[sv/rdq_pkg.sv]
// Shared types and codes for the reversible deque.
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

    // Command codes carried in the input transaction
    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_REVERSE    = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation on the physical cell row (front sits in cell 0)
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_PUSH_BACK  = 3'd3,
        OP_POP_BACK   = 3'd4
    } phys_op_t;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // Decoded command handed from the decoder to the top level
    typedef struct packed {
        phys_op_t op;
        status_t  status;
        logic     pop;
        logic     toggle;
    } rdq_dec_t;

endpackage

`default_nettype wire

[sv/rdq_cell.sv]
// One storage cell of the deque row: holds an entry and its occupancy bit.
`timescale 1ns / 1ps
`default_nettype none

module rdq_cell
    import rdq_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire phys_op_t              op,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic                  left_occ,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic                  right_occ,
    output logic      [DATA_WIDTH-1:0] data,
    output logic                       occ,
    output logic      [DATA_WIDTH-1:0] tail_data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occ_reg;
    logic                  occ_next;
    logic                  first_free;
    logic                  is_tail;

    assign first_free = !occ_reg && left_occ;
    assign is_tail    = occ_reg && !right_occ;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (op)
            OP_PUSH_FRONT:
            begin
                // shift towards the back, cell 0 takes the new entry
                data_next = left_data;
                occ_next  = left_occ;
            end
            OP_POP_FRONT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            OP_PUSH_BACK:
            begin
                if (first_free)
                begin
                    data_next = push_data;
                    occ_next  = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (is_tail)
                begin
                    occ_next = 1'b0;
                end
            end
            default:
            begin
                data_next = data_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign occ       = occ_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

`default_nettype wire

[sv/rdq_decode.sv]
// Command decoder: maps a command and the reverse flag onto a row operation.
`timescale 1ns / 1ps
`default_nettype none

module rdq_decode
    import rdq_pkg::*;
(
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic             reversed,
    input  wire logic             full,
    input  wire logic             empty,
    output rdq_dec_t              dec
);

    always_comb
    begin
        dec        = '{op: OP_HOLD, status: ST_OK, pop: 1'b0, toggle: 1'b0};
        unique case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    dec.status = ST_FULL;
                end
                else if ((cmd == CMD_PUSH_BACK) != reversed)
                begin
                    dec.op = OP_PUSH_BACK;
                end
                else
                begin
                    dec.op = OP_PUSH_FRONT;
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    dec.status = ST_EMPTY;
                end
                else
                begin
                    dec.pop = 1'b1;
                    if ((cmd == CMD_POP_BACK) != reversed)
                    begin
                        dec.op = OP_POP_BACK;
                    end
                    else
                    begin
                        dec.op = OP_POP_FRONT;
                    end
                end
            end
            CMD_REVERSE:
            begin
                dec.toggle = 1'b1;
            end
            default:
            begin
                // unused codes leave everything alone
                dec.op = OP_HOLD;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/reversible_deque.sv]
// Top level of the reversible deque: cell row, decoder and result register.
`timescale 1ns / 1ps
`default_nettype none

// A bounded double-ended queue of DEPTH entries of DATA_WIDTH bits. Entries live
// in a row of cells with the physical front in cell 0; a front push or pop shifts
// the whole row by one cell, while a back push or pop touches only the cell at the
// edge of the occupied run. Reverse toggles a flag that swaps front and back for
// later commands. Each command is one input transaction and yields one result
// transaction in the cycle after acceptance; a new command is taken every cycle in
// which the result register is empty or being drained, so the rate is one command
// per clock while the output side keeps up. The pop-back read path combines the
// tail cell's word across all DEPTH cells, which sets the clock limit for deep rows.
module reversible_deque
    import rdq_pkg::*;
#(
    parameter int  DEPTH      = 16,
    parameter int  DATA_WIDTH = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int IN_W       = ((CMD_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int RES_W      = DATA_WIDTH + 1 + STATUS_W + CNT_W + 1,
    localparam int OUT_W      = ((RES_W + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // fields from bit 0: cmd, push_data
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // fields from bit 0: pop_data, pop_valid, status, entry_count, is_empty
    output logic      [OUT_W-1:0] m_axis_tdata
);

    logic [CMD_W-1:0]      cmd;
    logic [DATA_WIDTH-1:0] push_data;
    logic                  s_fire;
    rdq_dec_t              dec;
    phys_op_t              cell_op;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  cell_occ  [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
    logic [DATA_WIDTH-1:0] back_data;
    logic [DATA_WIDTH-1:0] pop_data;

    logic                  rev_reg;
    logic                  rev_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic [OUT_W-1:0]      out_data_next;

    assign cmd       = s_axis_tdata[CMD_W-1:0];
    assign push_data = s_axis_tdata[CMD_W +: DATA_WIDTH];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    rdq_decode u_decode (
        .cmd      (cmd),
        .reversed (rev_reg),
        .full     (cell_occ[DEPTH-1]),
        .empty    (!cell_occ[0]),
        .dec      (dec)
    );

    assign cell_op = s_fire ? dec.op : OP_HOLD;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic                  left_occ;
        logic [DATA_WIDTH-1:0] right_data;
        logic                  right_occ;

        if (i == 0)
        begin : g_first
            assign left_data = push_data;
            assign left_occ  = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
            assign left_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = '0;
            assign right_occ  = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
            assign right_occ  = cell_occ[i+1];
        end

        rdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (cell_op),
            .push_data  (push_data),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i]),
            .tail_data  (cell_tail[i])
        );
    end

    // only the tail cell drives a non-zero word
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | cell_tail[i];
        end
    end

    always_comb
    begin
        priority if (!dec.pop)
        begin
            pop_data = '0;
        end
        else if (dec.op == OP_POP_FRONT)
        begin
            pop_data = cell_data[0];
        end
        else
        begin
            pop_data = back_data;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (dec.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: cnt_next = cnt_reg + CNT_W'(1);
            OP_POP_FRONT, OP_POP_BACK:   cnt_next = cnt_reg - CNT_W'(1);
            default:                     cnt_next = cnt_reg;
        endcase
    end

    assign rev_next = rev_reg ^ dec.toggle;

    assign out_data_next = OUT_W'({(cnt_next == '0), cnt_next, dec.status, dec.pop,
                                   pop_data});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_fire)
            begin
                rev_reg <= rev_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[sv/rdq_checker.sv]
// Port-level checks on the reversible deque, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rdq_checker
    import rdq_pkg::*;
#(
    parameter int  DEPTH      = 16,
    parameter int  DATA_WIDTH = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int RES_W      = DATA_WIDTH + 1 + STATUS_W + CNT_W + 1,
    localparam int OUT_W      = ((RES_W + 7) / 8) * 8
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    logic [DATA_WIDTH-1:0] pop_data;
    logic                  pop_valid;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_empty;

    assign pop_data    = m_axis_tdata[DATA_WIDTH-1:0];
    assign pop_valid   = m_axis_tdata[DATA_WIDTH];
    assign status      = m_axis_tdata[DATA_WIDTH+1 +: STATUS_W];
    assign entry_count = m_axis_tdata[DATA_WIDTH+1+STATUS_W +: CNT_W];
    assign is_empty    = m_axis_tdata[DATA_WIDTH+1+STATUS_W+CNT_W];

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (is_empty == (entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status == ST_EMPTY) |->
            (entry_count == '0 && !pop_valid && pop_data == '0))
        else $error("empty status on a non-empty deque or with popped data");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status == ST_FULL) |->
            (entry_count == CNT_W'(DEPTH) && !pop_valid))
        else $error("full status while the deque is not full");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && pop_valid) |->
            (status == ST_OK && entry_count != CNT_W'(DEPTH)))
        else $error("popped data with a bad status or a full count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind reversible_deque rdq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_rdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the reversible deque.
`timescale 1ns / 1ps

module tb;
    import rdq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 48;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 120;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int MAX_REPORTS  = 10;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] pop_data;
        logic                  pop_valid;
        status_t               status;
        logic [4:0]            entry_count;
        logic                  is_empty;
    } reply_t;

    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] ring [DEPTH];
        int unsigned head;
        int unsigned held;
        bit          flipped;
        reply_t      replies [$];
        int          errors;

        function new();
            head    = 0;
            held    = 0;
            flipped = 0;
            errors  = 0;
        endfunction

        function void log_failure(string why, reply_t want, reply_t got);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%0t: %s: expected data %h valid %b status %0d count %0d empty %b",
                         $realtime, why, want.pop_data, want.pop_valid, want.status,
                         want.entry_count, want.is_empty);
                $display("%0t: %s: actual   data %h valid %b status %0d count %0d empty %b",
                         $realtime, why, got.pop_data, got.pop_valid, got.status,
                         got.entry_count, got.is_empty);
            end
        endfunction

        function status_t put_front(logic [DATA_WIDTH-1:0] d);
            if (held >= DEPTH)
                return ST_FULL;
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = d;
            held++;
            return ST_OK;
        endfunction

        function status_t put_back(logic [DATA_WIDTH-1:0] d);
            if (held >= DEPTH)
                return ST_FULL;
            ring[(head + held) % DEPTH] = d;
            held++;
            return ST_OK;
        endfunction

        function status_t take_front(ref reply_t r);
            if (held == 0)
                return ST_EMPTY;
            r.pop_data  = ring[head];
            r.pop_valid = 1'b1;
            head = (head + 1) % DEPTH;
            held--;
            return ST_OK;
        endfunction

        function status_t take_back(ref reply_t r);
            if (held == 0)
                return ST_EMPTY;
            r.pop_data  = ring[(head + held - 1) % DEPTH];
            r.pop_valid = 1'b1;
            held--;
            return ST_OK;
        endfunction

        // work out the reply for an accepted command and queue it
        function void note_command(logic [2:0] c, logic [DATA_WIDTH-1:0] d);
            reply_t r;
            r = '0;
            r.status = ST_OK;
            case (c)
                CMD_PUSH_BACK:  r.status = flipped ? put_front(d) : put_back(d);
                CMD_PUSH_FRONT: r.status = flipped ? put_back(d) : put_front(d);
                CMD_POP_BACK:   r.status = flipped ? take_front(r) : take_back(r);
                CMD_POP_FRONT:  r.status = flipped ? take_back(r) : take_front(r);
                CMD_REVERSE:    flipped = !flipped;
                default: ;
            endcase
            r.entry_count = held[4:0];
            r.is_empty    = (held == 0);
            replies.push_back(r);
        endfunction

        function void check_reply(logic [OUT_W-1:0] raw);
            reply_t got;
            reply_t want;
            got.pop_data    = raw[31:0];
            got.pop_valid   = raw[32];
            got.status      = status_t'(raw[34:33]);
            got.entry_count = raw[39:35];
            got.is_empty    = raw[40];
            if (replies.size() == 0)
            begin
                log_failure("unexpected result", got, got);
                return;
            end
            want = replies.pop_front();
            if (got.pop_data !== want.pop_data || got.pop_valid !== want.pop_valid ||
                got.status !== want.status || got.entry_count !== want.entry_count ||
                got.is_empty !== want.is_empty)
                log_failure("mismatch", want, got);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    bit          tail_quiet = 1'b0;
    int unsigned cycles = 0;

    deque_scoreboard board = new();

    reversible_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // record every transaction on both sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_command(s_axis_tdata[2:0], s_axis_tdata[34:3]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_reply(m_axis_tdata);
        end
    end

    // output back-pressure in bursts; none in the tail
    initial
    begin
        int  burst_left;
        bit  stalling;
        burst_left = 0;
        stalling   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (tail_quiet)
                m_axis_tready <= 1'b1;
            else
            begin
                if (burst_left == 0)
                begin
                    stalling   = ($urandom_range(0, 2) == 0);
                    burst_left = stalling ? $urandom_range(1, 11) : $urandom_range(1, 30);
                end
                burst_left--;
                m_axis_tready <= !stalling;
            end
        end
    end

    // caller stands at a falling edge; returns at the falling edge after acceptance
    task automatic send_command(input logic [2:0] c, input logic [DATA_WIDTH-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, d, c};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic hold_off_input();
        if (!tail_quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_command(traffic_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == MODE_FILL)
        begin
            if (r < 35) return CMD_PUSH_BACK;
            if (r < 70) return CMD_PUSH_FRONT;
            if (r < 80) return CMD_POP_BACK;
            if (r < 90) return CMD_POP_FRONT;
        end
        else if (mode == MODE_DRAIN)
        begin
            if (r < 10) return CMD_PUSH_BACK;
            if (r < 20) return CMD_PUSH_FRONT;
            if (r < 55) return CMD_POP_BACK;
            if (r < 90) return CMD_POP_FRONT;
        end
        else
        begin
            if (r < 22) return CMD_PUSH_BACK;
            if (r < 44) return CMD_PUSH_FRONT;
            if (r < 66) return CMD_POP_BACK;
            if (r < 88) return CMD_POP_FRONT;
        end
        if (r < 96) return CMD_REVERSE;
        return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    initial
    begin
        traffic_mode_t mode;
        int            seg_left;
        mode     = MODE_FILL;
        seg_left = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed opening: empty pops, data extremes, reverse, ignored codes
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_POP_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'h0000_0000);
        hold_off_input();
        send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_REVERSE, 32'h0);
        send_command(CMD_PUSH_BACK, 32'hA5A5_A5A5);
        hold_off_input();
        send_command(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_SPARE_LO, 32'hDEAD_BEEF);
        send_command(3'd6, 32'h1234_5678);
        send_command(CMD_SPARE_HI, 32'hFFFF_FFFF);
        send_command(CMD_REVERSE, 32'hFFFF_FFFF);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_POP_FRONT, 32'h0);

        // random traffic in phases that fill, drain or mix the deque
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (seg_left == 0)
            begin
                mode     = traffic_mode_t'($urandom_range(0, 2));
                seg_left = $urandom_range(10, 50);
            end
            seg_left--;
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                tail_quiet = 1'b1;
            hold_off_input();
            send_command(pick_command(mode), pick_word());
        end
        s_axis_tvalid <= 1'b0;

        while (board.replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.errors == 0 && board.replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
sv/rdq_pkg.sv
sv/rdq_cell.sv
sv/rdq_decode.sv
sv/reversible_deque.sv
sv/rdq_checker.sv
tb/tb.sv
